[design/plcb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcb_pkg: shared definitions for the particle cell list binning core
// Field widths, operation and status codes, register indexes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package plcb_pkg;

	// fixed field widths of the stream and config port
	localparam int KIND_W      = 2;
	localparam int ID_W        = 6;
	localparam int POS_W       = 16;
	localparam int DIMCFG_W    = 5;
	localparam int STATUS_W    = 3;
	localparam int CELLIDX_W   = 12;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 24;

	// default sizing
	localparam int DEF_MAX_PARTICLES = 64;
	localparam int DEF_MAX_CELLS     = 16;

	// operation kinds
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NEIGHBOUR  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NONE       = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OUTSIDE    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ALREADY    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_PLACED = 3'd5;
	localparam logic [STATUS_W-1:0] ST_CLEARED    = 3'd6;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_Z = 3'd5;

	// config reset values
	localparam logic [DIMCFG_W-1:0] RST_CELLS = 5'd16;
	localparam logic [POS_W-1:0]    RST_WIDTH = 16'd256;

	// source of the result payload
	typedef enum logic [1:0] {
		SRC_ZERO,
		SRC_PCELL,
		SRC_CELL,
		SRC_PEND
	} out_src_t;

	// source of the divider operands
	typedef enum logic [1:0] {
		DIV_BIN,
		DIV_OWN,
		DIV_REM
	} div_src_t;

	typedef struct packed {
		logic                load;
		logic                clear_placed;
		logic                clr_step;
		logic                div_start;
		div_src_t            div_src;
		logic                bin_store;
		logic                x_store;
		logic                yz_store;
		logic                cell_load;
		logic                cell_from_nb;
		logic                insert_commit;
		logic                off_clr;
		logic                off_inc;
		logic                pend_clr;
		logic                pend_push;
		logic                cur_from_head;
		logic                cur_from_link;
		logic                out_load;
		logic [STATUS_W-1:0] out_status;
		out_src_t            out_src;
		logic                out_last;
	} cmd_t;

	typedef struct packed {
		logic in_id_ok;
		logic clr_last;
		logic placed;
		logic div_done;
		logic bin_fail;
		logic axis_last;
		logic nb_in;
		logic off_last;
		logic head_zero;
		logic link_zero;
		logic cur_is_self;
		logic pend_v;
	} stat_t;

endpackage

[design/plcb_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcb_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plcb_div #(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);

	localparam int CNTW = $clog2(W + 1);

	logic [W-1:0]    rem_q;
	logic [W-1:0]    quo_q;
	logic [W-1:0]    den_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [W:0]      trial;
	logic            fit;

	// shift in the next dividend bit and try the subtract
	assign trial = {rem_q, quo_q[W-1]};
	assign fit   = trial >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fit ? W'(trial - {1'b0, den_q}) : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], fit};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

[design/plcb_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcb_datapath: cell list storage and arithmetic
// Holds config registers, list heads, links, particle cells, the divider,
// neighbour offset walk and the result register.
// ----------------------------------------------------------------------------
module plcb_datapath #(
	parameter int MAX_PARTICLES      = plcb_pkg::DEF_MAX_PARTICLES,
	parameter int MAX_CELLS_PER_AXIS = plcb_pkg::DEF_MAX_CELLS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [plcb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [plcb_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [plcb_pkg::ID_W-1:0]         in_particle_id,
	input  logic [plcb_pkg::POS_W-1:0]        in_pos_x,
	input  logic [plcb_pkg::POS_W-1:0]        in_pos_y,
	input  logic [plcb_pkg::POS_W-1:0]        in_pos_z,
	input  plcb_pkg::cmd_t                    cmd,
	output plcb_pkg::stat_t                   st,
	output logic [plcb_pkg::STATUS_W-1:0]     res_status,
	output logic [plcb_pkg::ID_W-1:0]         res_neighbour_id,
	output logic [plcb_pkg::CELLIDX_W-1:0]    res_cell_index,
	output logic                              res_last
);

	localparam int IW    = $clog2(MAX_PARTICLES);
	localparam int LW    = $clog2(MAX_PARTICLES + 1);
	localparam int AW    = $clog2(MAX_CELLS_PER_AXIS);
	localparam int DW    = $clog2(MAX_CELLS_PER_AXIS + 1);
	localparam int CW    = 3 * AW;
	localparam int YZW   = 2 * DW;
	localparam int NCELL = 1 << CW;
	localparam int DVW   = (CW > plcb_pkg::POS_W) ? CW : plcb_pkg::POS_W;
	localparam int PW    = plcb_pkg::POS_W;

	// config registers
	logic [plcb_pkg::DIMCFG_W-1:0] cells_q [3];
	logic [PW-1:0]                 width_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				cells_q[i] <= plcb_pkg::RST_CELLS;
				width_q[i] <= plcb_pkg::RST_WIDTH;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				plcb_pkg::REG_CELLS_X: cells_q[0] <= cfg_data[plcb_pkg::DIMCFG_W-1:0];
				plcb_pkg::REG_CELLS_Y: cells_q[1] <= cfg_data[plcb_pkg::DIMCFG_W-1:0];
				plcb_pkg::REG_CELLS_Z: cells_q[2] <= cfg_data[plcb_pkg::DIMCFG_W-1:0];
				plcb_pkg::REG_WIDTH_X: width_q[0] <= cfg_data;
				plcb_pkg::REG_WIDTH_Y: width_q[1] <= cfg_data;
				plcb_pkg::REG_WIDTH_Z: width_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// zero counts act as one, large counts saturate at the grid size
	function automatic logic [DW-1:0] clamp_dim(input logic [plcb_pkg::DIMCFG_W-1:0] v);
		logic [DW-1:0] r;
		if (v == '0) r = DW'(1);
		else if (32'(v) > MAX_CELLS_PER_AXIS) r = DW'(MAX_CELLS_PER_AXIS);
		else r = DW'(v);
		return r;
	endfunction

	logic [DW-1:0] dim [3];
	always_comb begin
		for (int i = 0; i < 3; i++) dim[i] = clamp_dim(cells_q[i]);
	end

	// operation registers
	logic [IW-1:0]  id_q;
	logic [PW-1:0]  pos_q [3];
	logic [YZW-1:0] yz_q;
	logic [1:0]     axis_q;
	logic [CW-1:0]  coord_q [3];
	logic [1:0]     off_q [3];
	logic [CW-1:0]  cell_q;
	logic [IW-1:0]  cur_q;
	logic           pend_v_q;
	logic [IW-1:0]  pend_id_q;
	logic [CW-1:0]  pend_cell_q;
	logic [CW-1:0]  clr_q;
	logic [MAX_PARTICLES-1:0] placed_q;

	// memory read data
	logic [LW-1:0] head_rd;
	logic [LW-1:0] link_rd;
	logic [CW-1:0] pcell_rd;

	// divider
	logic           div_done;
	logic [DVW-1:0] div_quot;
	logic [DVW-1:0] div_rem;
	logic [DVW-1:0] div_dividend;
	logic [DVW-1:0] div_divisor;
	logic [PW-1:0]  pos_sel;
	logic [PW-1:0]  width_sel;
	logic [DW-1:0]  dim_sel;

	always_comb begin
		case (axis_q)
			2'd0: begin
				pos_sel   = pos_q[0];
				width_sel = width_q[0];
				dim_sel   = dim[0];
			end
			2'd1: begin
				pos_sel   = pos_q[1];
				width_sel = width_q[1];
				dim_sel   = dim[1];
			end
			default: begin
				pos_sel   = pos_q[2];
				width_sel = width_q[2];
				dim_sel   = dim[2];
			end
		endcase
	end

	// operand select: bin position, split own cell by y*z, then by z
	always_comb begin
		case (cmd.div_src)
			plcb_pkg::DIV_BIN: begin
				div_dividend = (pos_sel == '0) ? '0 : DVW'(pos_sel - PW'(1));
				div_divisor  = DVW'(width_sel);
			end
			plcb_pkg::DIV_OWN: begin
				div_dividend = DVW'(pcell_rd);
				div_divisor  = DVW'(yz_q);
			end
			plcb_pkg::DIV_REM: begin
				div_dividend = div_rem;
				div_divisor  = DVW'(dim[2]);
			end
			default: begin
				div_dividend = '0;
				div_divisor  = DVW'(1);
			end
		endcase
	end

	plcb_div #(.W(DVW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// neighbour coordinates and range check
	logic [CW:0]   n_ext [3];
	logic [AW-1:0] n_c [3];
	logic [2:0]    in_ax;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n_ext[i] = {1'b0, coord_q[i]} + (CW+1)'(off_q[i]);
			in_ax[i] = (n_ext[i] != '0) && (n_ext[i] <= (CW+1)'(dim[i]));
			n_c[i]   = AW'(n_ext[i] - (CW+1)'(1));
		end
	end

	// cell index = x*Y*Z + y*Z + z
	logic [AW-1:0] ca;
	logic [AW-1:0] cb;
	logic [AW-1:0] cc;
	logic [CW-1:0] prod_a;
	logic [CW-1:0] prod_b;
	logic [CW-1:0] cell_sum;
	always_comb begin
		ca       = cmd.cell_from_nb ? n_c[0] : AW'(coord_q[0]);
		cb       = cmd.cell_from_nb ? n_c[1] : AW'(coord_q[1]);
		cc       = cmd.cell_from_nb ? n_c[2] : AW'(coord_q[2]);
		prod_a   = CW'(ca) * CW'(yz_q);
		prod_b   = CW'(cb) * CW'(dim[2]);
		cell_sum = prod_a + prod_b + CW'(cc);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q   <= '0;
			pend_v_q <= 1'b0;
			clr_q    <= '0;
			placed_q <= '0;
			for (int i = 0; i < 3; i++) off_q[i] <= '0;
		end else begin
			if (cmd.load) axis_q <= '0;
			else if (cmd.bin_store) axis_q <= axis_q + 2'd1;
			if (cmd.clr_step) clr_q <= clr_q + CW'(1);
			if (cmd.clear_placed) placed_q <= '0;
			else if (cmd.insert_commit) placed_q[id_q] <= 1'b1;
			if (cmd.pend_clr) pend_v_q <= 1'b0;
			else if (cmd.pend_push) pend_v_q <= 1'b1;
			// z innermost, x outermost
			if (cmd.off_clr) begin
				for (int i = 0; i < 3; i++) off_q[i] <= '0;
			end else if (cmd.off_inc) begin
				if (off_q[2] != 2'd2) begin
					off_q[2] <= off_q[2] + 2'd1;
				end else begin
					off_q[2] <= '0;
					if (off_q[1] != 2'd2) begin
						off_q[1] <= off_q[1] + 2'd1;
					end else begin
						off_q[1] <= '0;
						off_q[0] <= off_q[0] + 2'd1;
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q     <= IW'(in_particle_id);
			pos_q[0] <= in_pos_x;
			pos_q[1] <= in_pos_y;
			pos_q[2] <= in_pos_z;
			yz_q     <= YZW'(dim[1]) * YZW'(dim[2]);
		end
		if (cmd.bin_store) coord_q[axis_q] <= CW'(div_quot);
		if (cmd.x_store) coord_q[0] <= CW'(div_quot);
		if (cmd.yz_store) begin
			coord_q[1] <= CW'(div_quot);
			coord_q[2] <= CW'(div_rem);
		end
		if (cmd.cell_load) cell_q <= cell_sum;
		if (cmd.cur_from_head) cur_q <= IW'(head_rd - LW'(1));
		else if (cmd.cur_from_link) cur_q <= IW'(link_rd - LW'(1));
		if (cmd.pend_push) begin
			pend_id_q   <= cur_q;
			pend_cell_q <= cell_q;
		end
	end

	// list heads per cell, holding id+1 with zero for empty
	logic [LW-1:0] head_mem [NCELL];
	always_ff @(posedge clk) begin
		if (cmd.clr_step) head_mem[clr_q] <= '0;
		else if (cmd.insert_commit) head_mem[cell_q] <= LW'(id_q) + LW'(1);
		head_rd <= head_mem[cell_q];
	end

	// next link per particle
	logic [LW-1:0] link_mem [MAX_PARTICLES];
	always_ff @(posedge clk) begin
		if (cmd.insert_commit) link_mem[id_q] <= head_rd;
		link_rd <= link_mem[cur_q];
	end

	// stored cell per particle
	logic [CW-1:0] pcell_mem [MAX_PARTICLES];
	always_ff @(posedge clk) begin
		if (cmd.insert_commit) pcell_mem[id_q] <= cell_q;
		pcell_rd <= pcell_mem[id_q];
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_status <= cmd.out_status;
			res_last   <= cmd.out_last;
			case (cmd.out_src)
				plcb_pkg::SRC_PCELL: begin
					res_neighbour_id <= '0;
					res_cell_index   <= plcb_pkg::CELLIDX_W'(pcell_rd);
				end
				plcb_pkg::SRC_CELL: begin
					res_neighbour_id <= '0;
					res_cell_index   <= plcb_pkg::CELLIDX_W'(cell_q);
				end
				plcb_pkg::SRC_PEND: begin
					res_neighbour_id <= plcb_pkg::ID_W'(pend_id_q);
					res_cell_index   <= plcb_pkg::CELLIDX_W'(pend_cell_q);
				end
				default: begin
					res_neighbour_id <= '0;
					res_cell_index   <= '0;
				end
			endcase
		end
	end

	// status to the controller
	always_comb begin
		st.in_id_ok    = 32'(in_particle_id) < MAX_PARTICLES;
		st.clr_last    = &clr_q;
		st.placed      = placed_q[id_q];
		st.div_done    = div_done;
		st.bin_fail    = (width_sel == '0) || (div_quot >= DVW'(dim_sel));
		st.axis_last   = axis_q == 2'd2;
		st.nb_in       = &in_ax;
		st.off_last    = (off_q[0] == 2'd2) && (off_q[1] == 2'd2) && (off_q[2] == 2'd2);
		st.head_zero   = head_rd == '0;
		st.link_zero   = link_rd == '0;
		st.cur_is_self = cur_q == id_q;
		st.pend_v      = pend_v_q;
	end

endmodule

[design/plcb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcb_ctrl: operation sequencer
// Steps insert, query and clear through the datapath and owns the
// stream handshakes.
// ----------------------------------------------------------------------------
module plcb_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [plcb_pkg::KIND_W-1:0]   kind,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	input  plcb_pkg::stat_t               st,
	output plcb_pkg::cmd_t                cmd
);

	typedef enum logic [4:0] {
		S_SWEEP,
		S_IDLE,
		S_LOOKUP,
		S_INS_CHK,
		S_INS_DIV,
		S_INS_CELL,
		S_INS_RD,
		S_INS_LINK,
		S_Q_CHK,
		S_Q_DIVX,
		S_Q_DIVY,
		S_Q_CELL,
		S_Q_RD,
		S_Q_HEAD,
		S_Q_VISIT,
		S_Q_NEXT,
		S_Q_END,
		S_EMIT
	} state_t;

	state_t                        state_q, state_d;
	logic                          out_valid_q, out_valid_d;
	logic [plcb_pkg::STATUS_W-1:0] emit_status_q, emit_status_d;
	plcb_pkg::out_src_t            emit_src_q, emit_src_d;
	logic                          sweep_emit_q, sweep_emit_d;
	logic                          is_query_q, is_query_d;
	logic                          out_free;

	// next state and commands
	always_comb begin
		cmd           = '0;
		state_d       = state_q;
		emit_status_d = emit_status_q;
		emit_src_d    = emit_src_q;
		sweep_emit_d  = sweep_emit_q;
		is_query_d    = is_query_q;
		s_tready      = 1'b0;
		out_free      = !out_valid_q || m_tready;
		case (state_q)
			S_SWEEP: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) begin
					if (sweep_emit_q) begin
						emit_status_d = plcb_pkg::ST_CLEARED;
						emit_src_d    = plcb_pkg::SRC_ZERO;
						state_d       = S_EMIT;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					case (kind)
						plcb_pkg::KIND_CLEAR: begin
							cmd.clear_placed = 1'b1;
							sweep_emit_d     = 1'b1;
							state_d          = S_SWEEP;
						end
						plcb_pkg::KIND_INSERT, plcb_pkg::KIND_QUERY: begin
							is_query_d = kind == plcb_pkg::KIND_QUERY;
							if (!st.in_id_ok) begin
								emit_status_d = plcb_pkg::ST_NOT_PLACED;
								emit_src_d    = plcb_pkg::SRC_ZERO;
								state_d       = S_EMIT;
							end else begin
								state_d = S_LOOKUP;
							end
						end
						default: begin
						end
					endcase
				end
			end
			// particle cell read in flight
			S_LOOKUP: begin
				state_d = is_query_q ? S_Q_CHK : S_INS_CHK;
			end
			S_INS_CHK: begin
				if (st.placed) begin
					emit_status_d = plcb_pkg::ST_ALREADY;
					emit_src_d    = plcb_pkg::SRC_PCELL;
					state_d       = S_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_src   = plcb_pkg::DIV_BIN;
					state_d       = S_INS_DIV;
				end
			end
			S_INS_DIV: begin
				cmd.div_src = plcb_pkg::DIV_BIN;
				if (st.div_done) begin
					if (st.bin_fail) begin
						emit_status_d = plcb_pkg::ST_OUTSIDE;
						emit_src_d    = plcb_pkg::SRC_ZERO;
						state_d       = S_EMIT;
					end else begin
						cmd.bin_store = 1'b1;
						state_d       = st.axis_last ? S_INS_CELL : S_INS_CHK;
					end
				end
			end
			S_INS_CELL: begin
				cmd.cell_load = 1'b1;
				state_d       = S_INS_RD;
			end
			S_INS_RD: begin
				state_d = S_INS_LINK;
			end
			S_INS_LINK: begin
				cmd.insert_commit = 1'b1;
				emit_status_d     = plcb_pkg::ST_INSERTED;
				emit_src_d        = plcb_pkg::SRC_CELL;
				state_d           = S_EMIT;
			end
			S_Q_CHK: begin
				if (!st.placed) begin
					emit_status_d = plcb_pkg::ST_NOT_PLACED;
					emit_src_d    = plcb_pkg::SRC_ZERO;
					state_d       = S_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_src   = plcb_pkg::DIV_OWN;
					state_d       = S_Q_DIVX;
				end
			end
			S_Q_DIVX: begin
				if (st.div_done) begin
					cmd.x_store   = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_src   = plcb_pkg::DIV_REM;
					state_d       = S_Q_DIVY;
				end
			end
			S_Q_DIVY: begin
				if (st.div_done) begin
					cmd.yz_store = 1'b1;
					cmd.off_clr  = 1'b1;
					cmd.pend_clr = 1'b1;
					state_d      = S_Q_CELL;
				end
			end
			S_Q_CELL: begin
				cmd.cell_from_nb = 1'b1;
				if (st.nb_in) begin
					cmd.cell_load = 1'b1;
					state_d       = S_Q_RD;
				end else if (st.off_last) begin
					state_d = S_Q_END;
				end else begin
					cmd.off_inc = 1'b1;
				end
			end
			S_Q_RD: begin
				state_d = S_Q_HEAD;
			end
			S_Q_HEAD: begin
				if (!st.head_zero) begin
					cmd.cur_from_head = 1'b1;
					state_d           = S_Q_VISIT;
				end else if (st.off_last) begin
					state_d = S_Q_END;
				end else begin
					cmd.off_inc = 1'b1;
					state_d     = S_Q_CELL;
				end
			end
			// hold one neighbour back so the final one can carry last
			S_Q_VISIT: begin
				if (st.cur_is_self) begin
					state_d = S_Q_NEXT;
				end else if (!st.pend_v || out_free) begin
					if (st.pend_v) begin
						cmd.out_load   = 1'b1;
						cmd.out_status = plcb_pkg::ST_NEIGHBOUR;
						cmd.out_src    = plcb_pkg::SRC_PEND;
						cmd.out_last   = 1'b0;
					end
					cmd.pend_push = 1'b1;
					state_d       = S_Q_NEXT;
				end
			end
			S_Q_NEXT: begin
				if (!st.link_zero) begin
					cmd.cur_from_link = 1'b1;
					state_d           = S_Q_VISIT;
				end else if (st.off_last) begin
					state_d = S_Q_END;
				end else begin
					cmd.off_inc = 1'b1;
					state_d     = S_Q_CELL;
				end
			end
			S_Q_END: begin
				if (st.pend_v) begin
					emit_status_d = plcb_pkg::ST_NEIGHBOUR;
					emit_src_d    = plcb_pkg::SRC_PEND;
				end else begin
					emit_status_d = plcb_pkg::ST_NONE;
					emit_src_d    = plcb_pkg::SRC_PCELL;
				end
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = emit_status_q;
					cmd.out_src    = emit_src_q;
					cmd.out_last   = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		out_valid_d = cmd.out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_q);
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_SWEEP;
			out_valid_q   <= 1'b0;
			emit_status_q <= plcb_pkg::ST_INSERTED;
			emit_src_q    <= plcb_pkg::SRC_ZERO;
			sweep_emit_q  <= 1'b0;
			is_query_q    <= 1'b0;
		end else begin
			state_q       <= state_d;
			out_valid_q   <= out_valid_d;
			emit_status_q <= emit_status_d;
			emit_src_q    <= emit_src_d;
			sweep_emit_q  <= sweep_emit_d;
			is_query_q    <= is_query_d;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

[design/particle_cell_list_binning_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_cell_list_binning_core: 3-D cell list binning with neighbour search
// Inserts particles into per-cell linked lists, walks the 27 surrounding
// cells on a query, and clears all lists on request.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream: one beat per operation, kind on s_tuser (insert, query,
//   clear), id and Q8.8 position on s_tdata. Master stream: result beats,
//   m_tlast on the final beat of each operation. Config: cfg_we writes
//   cfg_data into register cfg_index; the user must write only while the
//   core is idle, which the core itself does not enforce.
//   One operation is in flight at a time; s_tready is high only when idle.
//   Insert: bins each axis with the shared one-bit-per-cycle divider of
//   D = max(16, 3*log2(MAX_CELLS_PER_AXIS)) bits, then links the particle.
//   Query: decode, cell split, walk of the neighbour cells, final beat.
//   Clear: one cycle per list head, MAX_CELLS_PER_AXIS rounded up to a
//   power of two and cubed (4096 at defaults), then the cleared beat.
//   Reset: the same sweep of the list heads runs before the first beat is
//   taken; config writes are taken throughout.
//   A stalled master holds the result register; the walk waits on it.
// ----------------------------------------------------------------------------
module particle_cell_list_binning_core #(
	parameter int MAX_PARTICLES      = plcb_pkg::DEF_MAX_PARTICLES,
	parameter int MAX_CELLS_PER_AXIS = plcb_pkg::DEF_MAX_CELLS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// config write port
	input  logic                               cfg_we,
	input  logic [plcb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [plcb_pkg::CFG_DATA_W-1:0]    cfg_data,
	// operation stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// particle_id, pos_x, pos_y, pos_z, zero fill
	input  logic [plcb_pkg::IN_TDATA_W-1:0]    s_tdata,
	// kind
	input  logic [plcb_pkg::KIND_W-1:0]        s_tuser,
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// status, neighbour_id, cell_index, zero fill
	output logic [plcb_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                               m_tlast
);

	plcb_pkg::cmd_t                 cmd;
	plcb_pkg::stat_t                st;
	logic [plcb_pkg::STATUS_W-1:0]  res_status;
	logic [plcb_pkg::ID_W-1:0]      res_neighbour_id;
	logic [plcb_pkg::CELLIDX_W-1:0] res_cell_index;

	plcb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.kind     (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	plcb_datapath #(
		.MAX_PARTICLES      (MAX_PARTICLES),
		.MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_particle_id   (s_tdata[5:0]),
		.in_pos_x         (s_tdata[21:6]),
		.in_pos_y         (s_tdata[37:22]),
		.in_pos_z         (s_tdata[53:38]),
		.cmd              (cmd),
		.st               (st),
		.res_status       (res_status),
		.res_neighbour_id (res_neighbour_id),
		.res_cell_index   (res_cell_index),
		.res_last         (m_tlast)
	);

	// pack result beat
	assign m_tdata = {3'b000, res_cell_index, res_neighbour_id, res_status};

	// an accepted operation takes the core out of idle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != plcb_pkg::KIND_NONE |=> !s_tready)
		else $error("core still ready after accepting an operation");

	// status codes stay within the defined set
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= plcb_pkg::ST_CLEARED)
		else $error("undefined result status");

	// neighbour id only on neighbour beats
	a_nid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != plcb_pkg::ST_NEIGHBOUR |-> m_tdata[8:3] == '0)
		else $error("neighbour id on a non-neighbour result");

	// every non-neighbour result is the only result of its operation
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != plcb_pkg::ST_NEIGHBOUR |-> m_tlast)
		else $error("single result without last");

endmodule
